// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file lwts_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define LWTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define LWTS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- src/lwts_pkg.sv -----
// Package: widths and constants of the locality weighted target selector.
`default_nettype none

package lwts_pkg;

    localparam int MAX_CELLS_DEF = 64;

    localparam int CFG_W     = 7;   // cells_in_use
    localparam int CUR_W     = 6;   // current_cell
    localparam int RND_W     = 31;  // random_word
    localparam int TGT_W     = 6;   // target_cell

    localparam int S_TDATA_W = ((CUR_W + RND_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TGT_W + 7) / 8) * 8;

    // remainder bits resolved per modulo pipeline stage
    localparam int MOD_BPS   = 4;

endpackage

`default_nettype wire

// ----- src/locality_weighted_target_select.sv -----
// Locality weighted target select: pipelined roulette-wheel pick of a target cell.
//
// Usage:
//   Write cells_in_use through i_cfg_we / i_cfg_wdata while the block is idle
//   (0 counts as one cell, values above MAX_CELLS saturate).
//   Each transfer on s_axis carries current_cell and random_word; exactly one
//   transfer on m_axis follows, carrying target_cell, in request order.
//   Per-cell weights are built in one stage, summed by a Kogge-Stone prefix
//   network ($clog2(MAX_CELLS) stages), the random word is reduced modulo the
//   weight total by a restoring remainder pipeline (4 bits per stage, 8
//   stages), then compared against every prefix sum and priority encoded.
//   Throughput: one request per cycle while s_axis_tready is high.
//   When m_axis stalls the output register holds its item and a skid register
//   catches the next one; s_axis_tready then drops (a registered signal) and
//   the whole pipeline freezes until the output drains. Nothing is dropped.
//   Reset (i_rst_n low at a clock edge) empties the pipeline and sets the
//   cell count to one.
`default_nettype none

module locality_weighted_target_select #(
    parameter int MAX_CELLS = lwts_pkg::MAX_CELLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lwts_pkg::CFG_W-1:0]    i_cfg_wdata,     // cells_in_use
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] current_cell, [36:6] random_word, [39:37] zero
    input  wire logic [lwts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [5:0] target_cell, [7:6] zero
    output logic [lwts_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import lwts_pkg::*;

    localparam int LG = $clog2(MAX_CELLS);
    localparam int IW = (LG > 0) ? LG : 1;
    localparam int NW = $clog2(MAX_CELLS + 1);
    localparam int PS = (LG > 0) ? LG : 1;
    localparam int EW = $clog2(LG + 2);
    localparam int TW = IW + LG + 2;
    localparam int MS = (RND_W + MOD_BPS - 1) / MOD_BPS;
    localparam int RW = MS * MOD_BPS;

    // configuration
    logic [NW-1:0]  r_cnt, n_cnt;
    logic [EW-1:0]  r_lvl, n_lvl;

    // pipeline registers
    logic [TW-1:0]  r_pf   [0:PS][0:MAX_CELLS-1];
    logic [RW-1:0]  r_prnd [0:PS];
    logic           r_pv   [0:PS];

    logic [TW-1:0]  r_mpf  [0:MS-1][0:MAX_CELLS-1];
    logic [TW-1:0]  r_mrem [0:MS-1];
    logic [TW-1:0]  r_mtot [0:MS-1];
    logic [RW-1:0]  r_mrnd [0:MS-1];
    logic           r_mv   [0:MS-1];

    logic [MAX_CELLS-1:0] r_gt;
    logic                 r_cv;

    // output register and skid
    logic                 r_ov, r_sv;
    logic [TGT_W-1:0]     r_od, r_sd;

    logic                 w_en;
    logic [CUR_W-1:0]     w_cur;
    logic [RND_W-1:0]     w_rnd;
    logic [IW-1:0]        w_cc;
    logic [TW-1:0]        w_wt [0:MAX_CELLS-1];
    logic [IW-1:0]        w_pick;
    logic [TGT_W-1:0]     w_tgt;
    logic                 w_in;
    logic                 w_take;

    function automatic logic [TW-1:0] mod_step(
        input logic [TW-1:0]      rem,
        input logic [TW-1:0]      tot,
        input logic [MOD_BPS-1:0] bits
    );
        logic [TW:0]   t;
        logic [TW-1:0] r;
        r = rem;
        for (int i = MOD_BPS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, tot}) begin
                t = t - {1'b0, tot};
            end
            r = t[TW-1:0];
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    always_comb begin
        int lv;
        lv = 0;
        if (i_cfg_wdata == '0) begin
            n_cnt = NW'(1);
        end else if (int'(i_cfg_wdata) > MAX_CELLS) begin
            n_cnt = NW'(MAX_CELLS);
        end else begin
            n_cnt = NW'(i_cfg_wdata);
        end
        // number of block sizes 1, 2, 4, ... below the cell count
        for (int sh = 0; sh < LG; sh++) begin
            if ((1 << sh) < int'(n_cnt)) begin
                lv = lv + 1;
            end
        end
        n_lvl = EW'(lv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= NW'(1);
            r_lvl <= '0;
        end else if (i_cfg_we) begin
            r_cnt <= n_cnt;
            r_lvl <= n_lvl;
        end
    end

    // ---------------- weight stage ----------------
    assign w_en          = !r_sv;
    assign s_axis_tready = w_en;
    assign w_cur         = s_axis_tdata[CUR_W-1:0];
    assign w_rnd         = s_axis_tdata[CUR_W +: RND_W];

    always_comb begin
        if (int'(w_cur) >= int'(r_cnt)) begin
            w_cc = IW'(int'(r_cnt) - 1);
        end else begin
            w_cc = IW'(w_cur);
        end
    end

    // weight = 2^e, e = levels sharing a block with the current cell,
    // +1 below the current cell, current cell itself halved
    always_comb begin
        logic [IW-1:0] diff;
        int            blen;
        int            e;
        for (int j = 0; j < MAX_CELLS; j++) begin
            diff = IW'(j) ^ w_cc;
            blen = 0;
            for (int b = 0; b < IW; b++) begin
                if (diff[b]) begin
                    blen = b + 1;
                end
            end
            if (diff == '0) begin
                e = (r_lvl != '0) ? int'(r_lvl) - 1 : 0;
            end else if (IW'(j) < w_cc) begin
                e = int'(r_lvl) - blen + 1;
            end else begin
                e = int'(r_lvl) - blen;
            end
            if (j < int'(r_cnt)) begin
                w_wt[j] = TW'(1) << e;
            end else begin
                w_wt[j] = '0;
            end
        end
    end

    // ---------------- prefix, modulo and compare stages ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pf[0]   <= w_wt;
            r_prnd[0] <= RW'(w_rnd);
            for (int s = 1; s <= PS; s++) begin
                r_prnd[s] <= r_prnd[s-1];
                for (int j = 0; j < MAX_CELLS; j++) begin
                    if (j >= (1 << (s - 1))) begin
                        r_pf[s][j] <= r_pf[s-1][j] + r_pf[s-1][j - (1 << (s - 1))];
                    end else begin
                        r_pf[s][j] <= r_pf[s-1][j];
                    end
                end
            end

            // last prefix entry is the weight total (unused cells weigh zero)
            r_mpf[0]  <= r_pf[PS];
            r_mtot[0] <= r_pf[PS][MAX_CELLS-1];
            r_mrnd[0] <= r_prnd[PS];
            r_mrem[0] <= mod_step('0, r_pf[PS][MAX_CELLS-1],
                                  r_prnd[PS][RW-1 -: MOD_BPS]);
            for (int k = 1; k < MS; k++) begin
                r_mpf[k]  <= r_mpf[k-1];
                r_mtot[k] <= r_mtot[k-1];
                r_mrnd[k] <= r_mrnd[k-1];
                r_mrem[k] <= mod_step(r_mrem[k-1], r_mtot[k-1],
                                      r_mrnd[k-1][RW-1-k*MOD_BPS -: MOD_BPS]);
            end

            for (int j = 0; j < MAX_CELLS; j++) begin
                r_gt[j] <= (r_mpf[MS-1][j] > r_mrem[MS-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= PS; s++) begin
                r_pv[s] <= 1'b0;
            end
            for (int k = 0; k < MS; k++) begin
                r_mv[k] <= 1'b0;
            end
            r_cv <= 1'b0;
        end else if (w_en) begin
            r_pv[0] <= s_axis_tvalid;
            for (int s = 1; s <= PS; s++) begin
                r_pv[s] <= r_pv[s-1];
            end
            r_mv[0] <= r_pv[PS];
            for (int k = 1; k < MS; k++) begin
                r_mv[k] <= r_mv[k-1];
            end
            r_cv <= r_mv[MS-1];
        end
    end

    // first cell whose running sum exceeds the remainder
    always_comb begin
        w_pick = IW'(int'(r_cnt) - 1);
        for (int j = MAX_CELLS - 1; j >= 0; j--) begin
            if (r_gt[j]) begin
                w_pick = IW'(j);
            end
        end
    end

    assign w_tgt = TGT_W'(w_pick);

    // ---------------- output register with skid ----------------
    assign w_in   = r_cv && w_en;
    assign w_take = r_ov && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (w_in) begin
            if (!r_ov || w_take) begin
                r_od <= w_tgt;
                r_ov <= 1'b1;
            end else begin
                r_sd <= w_tgt;
                r_sv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = M_TDATA_W'(r_od);

endmodule

`default_nettype wire

// ----- src/lwts_chk.sv -----
// Port-level checker for the locality weighted target selector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lwts_chk #(
    parameter int MAX_CELLS = lwts_pkg::MAX_CELLS_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_we,
    input wire logic [lwts_pkg::CFG_W-1:0]     i_cfg_wdata,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [lwts_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import lwts_pkg::*;

    localparam int NW = $clog2(MAX_CELLS + 1);

    logic [NW-1:0] r_cnt, n_cnt;

    // shadow of the effective cell count
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cnt = NW'(1);
        end else if (int'(i_cfg_wdata) > MAX_CELLS) begin
            n_cnt = NW'(MAX_CELLS);
        end else begin
            n_cnt = NW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= NW'(1);
        end else if (i_cfg_we) begin
            r_cnt <= n_cnt;
        end
    end

    `LWTS_ASSERT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "output transfer changed while stalled")

    `LWTS_ASSERT(a_tgt_range, i_clk, i_rst_n,
        m_axis_tvalid |-> int'(m_axis_tdata[TGT_W-1:0]) < int'(r_cnt),
        "target cell outside cells in use")

    // input only stalls once a held output has met a stalled receiver
    `LWTS_ASSERT(a_ready_skid, i_clk, i_rst_n,
        !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready),
        "input stalled without a held output")

    `LWTS_ASSERT_NR(a_rst_empty, i_clk,
        $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready,
        "pipeline not empty after reset")

endmodule

bind locality_weighted_target_select lwts_chk #(.MAX_CELLS(MAX_CELLS)) u_lwts_chk (.*);

`default_nettype wire

// ----- verif/locality_weighted_target_select_tb.sv -----
// Testbench for locality_weighted_target_select: directed and random stream traffic checked against a predictor.
`default_nettype none

module locality_weighted_target_select_tb;

    import lwts_pkg::*;

    localparam int PAD_W       = S_TDATA_W - CUR_W - RND_W;
    localparam int LATENCY     = $clog2(MAX_CELLS_DEF) + 10;
    localparam int DRAIN_WAIT  = 4 * LATENCY;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 95;

    typedef struct packed {
        logic [RND_W-1:0] rnd;
        logic [CUR_W-1:0] cur;
    } t_select_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [5:0] current_cell, [36:6] random_word
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [5:0] target_cell

    locality_weighted_target_select i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_select_req       pending_reqs[$];
    logic [TGT_W-1:0]  expected_targets[$];
    logic [CFG_W-1:0]  cells_model = 7'd1;
    logic              gaps_on = 1'b0;
    logic              stalls_on = 1'b0;
    int unsigned       send_gap = 0;
    int unsigned       stall_left = 0;
    int unsigned       cycle_count = 0;
    int unsigned       req_count = 0;
    int unsigned       result_count = 0;
    int unsigned       cfg_count = 0;
    int unsigned       error_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic int unsigned eff_cells(input logic [CFG_W-1:0] cells);
        if (cells == 0) return 1;
        if (cells > MAX_CELLS_DEF) return MAX_CELLS_DEF;
        return 32'(cells);
    endfunction

    function automatic int unsigned clamp_cur(input int unsigned cur, input int unsigned n);
        return (cur >= n) ? n - 1 : cur;
    endfunction

    // weight doubles per aligned block shared with the caller, again below it; halved at the caller
    function automatic int unsigned locality_weight(input int unsigned j, input int unsigned cur,
                                                    input int unsigned n);
        int unsigned w;
        w = 1;
        for (int sh = 0; sh < 31 && (1 << sh) < n; sh++) begin
            if ((j >> sh) == (cur >> sh)) w = w << 1;
        end
        if (j < cur) w = w << 1;
        if (j == cur && w > 1) w = w >> 1;
        return w;
    endfunction

    function automatic int unsigned weight_total(input logic [CFG_W-1:0] cells,
                                                 input logic [CUR_W-1:0] cur_in);
        int unsigned n;
        int unsigned cur;
        int unsigned sum;
        n = eff_cells(cells);
        cur = clamp_cur(32'(cur_in), n);
        sum = 0;
        for (int unsigned j = 0; j < n; j++) sum += locality_weight(j, cur, n);
        return sum;
    endfunction

    function automatic logic [TGT_W-1:0] roulette_pick(input logic [CFG_W-1:0] cells,
                                                       input logic [CUR_W-1:0] cur_in,
                                                       input logic [RND_W-1:0] rnd);
        int unsigned n;
        int unsigned cur;
        int unsigned slot;
        int unsigned run;
        n = eff_cells(cells);
        cur = clamp_cur(32'(cur_in), n);
        slot = rnd % weight_total(cells, cur_in);
        run = 0;
        for (int unsigned j = 0; j < n; j++) begin
            run += locality_weight(j, cur, n);
            if (run > slot) return j[TGT_W-1:0];
        end
        return TGT_W'(n - 1);
    endfunction

    // ---------------- traffic shaping ----------------

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- driver / responder / monitors ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{PAD_W{1'b0}}, pending_reqs[0]};
                void'(pending_reqs.pop_front());
                send_gap <= gaps_on ? idle_len() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 3) == 0) stall_left <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_targets.push_back(roulette_pick(cells_model, s_axis_tdata[CUR_W-1:0],
                                                     s_axis_tdata[CUR_W +: RND_W]));
            req_count++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (expected_targets.size() == 0) begin
                $error("unexpected result transfer: target_cell=%0d", m_axis_tdata[TGT_W-1:0]);
                error_count++;
            end else begin
                if (m_axis_tdata[TGT_W-1:0] !== expected_targets[0]) begin
                    $error("target_cell mismatch: expected %0d, actual %0d",
                           expected_targets[0], m_axis_tdata[TGT_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[M_TDATA_W-1:TGT_W] !== '0) begin
                    $error("tdata pad mismatch: expected 0, actual %0h",
                           m_axis_tdata[M_TDATA_W-1:TGT_W]);
                    error_count++;
                end
                void'(expected_targets.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_targets.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- sequencing ----------------

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_targets.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_cells(input logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cells_model = value;
        cfg_count++;
    endtask

    task automatic push_req(input int unsigned cur, input int unsigned rnd);
        t_select_req req;
        req.cur = cur[CUR_W-1:0];
        req.rnd = rnd[RND_W-1:0];
        pending_reqs.push_back(req);
    endtask

    // random request, mostly with the caller inside the active range, and the
    // random word often within two wheel turns or at a wheel boundary
    task automatic push_random_req();
        int unsigned n;
        int unsigned cur;
        int unsigned rnd;
        int unsigned total;
        int unsigned roll;
        n = eff_cells(cells_model);
        cur = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
        total = weight_total(cells_model, cur[CUR_W-1:0]);
        roll = $urandom_range(0, 9);
        rnd = $urandom & 32'h7FFF_FFFF;
        if (roll < 4) begin
            rnd = $urandom_range(0, 2 * total - 1);
        end else if (roll < 6) begin
            rnd = rnd - (rnd % total);
            if (rnd >= total && $urandom_range(0, 1) == 1) rnd = rnd - 1;
        end
        push_req(cur, rnd);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_cells[RAND_PHASES];
        phase_cells = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd127, 7'd0, 7'd65, 7'd33, 7'd63, 7'd17};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, clamping, saturation, wheel edges
        write_cells(7'd64);
        push_req(0, 0);
        push_req(63, 32'h7FFF_FFFF);
        push_req(0, 32'h7FFF_FFFF);
        push_req(63, 0);
        push_req(0, weight_total(7'd64, 6'd0) - 1);
        push_req(63, weight_total(7'd64, 6'd63) - 1);
        push_req(32, weight_total(7'd64, 6'd32));
        push_req(21, 32'h2AAA_AAAA);
        push_req(42, 32'h5555_5555);
        write_cells(7'd0);
        push_req(0, 12345);
        push_req(63, 32'h7FFF_FFFF);
        write_cells(7'd127);
        push_req(10, 999);
        push_req(63, weight_total(7'd127, 6'd63) - 1);
        write_cells(7'd65);
        push_req(63, 7);
        write_cells(7'd5);
        push_req(63, 0);
        push_req(63, weight_total(7'd5, 6'd63) - 1);
        push_req(4, 3);
        push_req(5, weight_total(7'd5, 6'd5));
        write_cells(7'd1);
        push_req(0, 32'h7FFF_FFFF);
        push_req(63, 1);
        write_cells(7'd2);
        push_req(1, 0);
        push_req(1, 1);
        push_req(0, 2);

        for (int p = 0; p < RAND_PHASES + 2; p++) begin
            if (p < RAND_PHASES) write_cells(phase_cells[p]);
            else write_cells(CFG_W'($urandom_range(0, 127)));
            gaps_on <= (p % 3 != 1);
            stalls_on <= (p % 4 != 2);
            for (int k = 0; k < PHASE_ITEMS - 10 * (p / RAND_PHASES); k++) push_random_req();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_targets.size() != 0) begin
            $error("%0d expected results never arrived", expected_targets.size());
            error_count++;
        end

        $display("run covered %0d requests and %0d results over %0d cell-count settings",
                 req_count, result_count, cfg_count);
        $display("including zero, one, full and saturated cell counts, with random gaps and stalls");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
